// ===== hdl/pulse_width_capture_stats_macros.svh =====
// Assertion macros shared by the pulse width capture checker.
`ifndef PULSE_WIDTH_CAPTURE_STATS_MACROS_SVH
`define PULSE_WIDTH_CAPTURE_STATS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pwcs: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PWCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pwcs: next-cycle check failed");

`endif

// ===== hdl/pwcs_pkg.sv =====
// Shared types and constants of the pulse width capture block.
`default_nettype none

package pwcs_pkg;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_FLUSH = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTLOW = 2'd2;

  localparam int W_W    = 16;
  localparam int CNT_W  = 10;
  localparam int SUM_W  = 25;
  localparam int RIDX_W = 9;

  localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;
  localparam logic [SUM_W-1:0] SUM_MAX = 25'h1FFFFFF;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 112;
  localparam int OUT_USER_W = 2;
  localparam int OUT_PAD_W  = OUT_DATA_W - (4 * W_W + 2 * CNT_W + SUM_W);

  localparam int OFF_WIDTH = 0;
  localparam int OFF_RCNT  = OFF_WIDTH + W_W;
  localparam int OFF_MATCH = OFF_RCNT + CNT_W;
  localparam int OFF_MIN   = OFF_MATCH + W_W;
  localparam int OFF_MAX   = OFF_MIN + W_W;
  localparam int OFF_SUM   = OFF_MAX + W_W;
  localparam int OFF_QCNT  = OFF_SUM + SUM_W;

  localparam int USER_DONE = 0;
  localparam int USER_REC  = 1;

endpackage

`default_nettype wire

// ===== hdl/pulse_width_capture_stats.sv =====
// Pulse width capture with a width store and running statistics.
// A result word is registered in the first stage, second stage and output register in turn.
// Throughput: one word per cycle when unstalled; the store memory's single write port
// and registered read port serve end ticks and reads, with forwarding between neighbors.
// Reset clears all control, counters and statistics; store contents stay undefined
// until written and need no clearing pass.
`default_nettype none

module pulse_width_capture_stats #(
  parameter int RECORD_DEPTH = 512
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  // level [0], read_index [9:1], zero fill [15:10]
  input  wire  [pwcs_pkg::IN_DATA_W-1:0]         s_axis_tdata,
  // mode [1:0]
  input  wire  [pwcs_pkg::IN_USER_W-1:0]         s_axis_tuser,
  input  wire                                    s_axis_tvalid,
  output logic                                   s_axis_tready,
  // width [15:0], record_count [25:16], match_count [41:26], min_width [57:42],
  // max_width [73:58], width_sum [98:74], qualified_count [108:99], zero fill [111:109]
  output logic [pwcs_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // pulse_done [0], recorded [1]
  output logic [pwcs_pkg::OUT_USER_W-1:0]        m_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire                                    m_axis_tready,
  input  wire                                    cfg_we_i,
  input  wire  [pwcs_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire  [pwcs_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  import pwcs_pkg::*;

  localparam int CW = $clog2(RECORD_DEPTH + 1);
  localparam int AW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
  localparam int XW = (CW > RIDX_W) ? CW : RIDX_W;
  localparam int SW = (CW > CNT_W) ? CW : CNT_W;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_END   = 2'd1,
    OP_READ  = 2'd2,
    OP_FLUSH = 2'd3
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            rec;
    logic [W_W-1:0]  tick;
    logic [W_W-1:0]  wraps;
    logic [AW-1:0]   addr;
    logic            hit;
    logic [CNT_W-1:0] rcnt;
    logic [W_W-1:0]  match;
  } s1_t;

  typedef struct packed {
    op_e             op;
    logic            rec;
    logic [W_W-1:0]  tick;
    logic [W_W-1:0]  prod;
    logic [AW-1:0]   addr;
    logic            hit;
    logic [CNT_W-1:0] rcnt;
    logic [W_W-1:0]  match;
    logic            fwd;
    logic [W_W-1:0]  fwd_data;
  } s2_t;

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CW-1:0] c);
    logic [SW-1:0] x;
    x = SW'(c);
    return (x > SW'(CNT_MAX)) ? CNT_MAX : x[CNT_W-1:0];
  endfunction

  // Configuration registers.
  logic [16:0]    period_q;
  logic [W_W-1:0] thr_q;
  logic           act_low_q;
  logic [16:0]    per_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= 17'h10000;
      thr_q     <= 16'd20;
      act_low_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PERIOD: period_q  <= cfg_data_i;
        CFG_THRESH: thr_q     <= cfg_data_i[W_W-1:0];
        CFG_ACTLOW: act_low_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (period_q == 17'd0) begin
      per_eff = 17'd1;
    end else if (period_q > 17'h10000) begin
      per_eff = 17'h10000;
    end else begin
      per_eff = period_q;
    end
  end

  // Handshake and stage occupancy.
  logic s1_v_q, s2_v_q, ov_q;
  logic out_adv, s2_free, s1_go, s1_free, acc, wr_en;

  assign out_adv       = !ov_q || m_axis_tready;
  assign s2_free       = !s2_v_q || out_adv;
  assign s1_go         = s1_v_q && s2_free;
  assign s1_free       = !s1_v_q || s2_free;
  assign s_axis_tready = s1_free;
  assign acc           = s_axis_tvalid && s1_free;
  assign m_axis_tvalid = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_q <= acc;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
      if (out_adv) begin
        ov_q <= s2_v_q;
      end
    end
  end

  // Pulse tracking state, updated as each word is accepted.
  mode_e             in_mode;
  logic              in_level;
  logic [RIDX_W-1:0] in_ridx;
  logic              in_pulse_q, in_pulse_d;
  logic              prev_q, prev_d;
  logic [W_W-1:0]    tick_q, tick_d;
  logic [W_W-1:0]    wraps_q, wraps_d;
  logic [W_W-1:0]    wtot_q, wtot_d;
  logic [CW-1:0]     scnt_q, scnt_d;
  logic [16:0]       nxt;
  logic              wrap, active, was_active;
  logic [XW-1:0]     ridx_x;
  s1_t               s1_d, s1_q;

  assign in_mode  = mode_e'(s_axis_tuser);
  assign in_level = s_axis_tdata[0];
  assign in_ridx  = s_axis_tdata[RIDX_W:1];

  always_comb begin
    in_pulse_d = in_pulse_q;
    prev_d     = prev_q;
    tick_d     = tick_q;
    wraps_d    = wraps_q;
    wtot_d     = wtot_q;
    scnt_d     = scnt_q;
    s1_d       = '0;
    nxt        = {1'b0, tick_q} + 17'd1;
    wrap       = (nxt >= per_eff);
    active     = in_level ^ act_low_q;
    was_active = prev_q ^ act_low_q;
    ridx_x     = XW'(in_ridx);
    unique case (in_mode)
      MODE_TICK: begin
        prev_d = in_level;
        if (in_pulse_q) begin
          tick_d = wrap ? '0 : nxt[W_W-1:0];
          if (wrap) begin
            wraps_d = wraps_q + 16'd1;
            wtot_d  = wtot_q + 16'd1;
          end
          if (!active) begin
            in_pulse_d = 1'b0;
            s1_d.op    = OP_END;
            s1_d.tick  = tick_d;
            s1_d.wraps = wraps_d;
            s1_d.addr  = scnt_q[AW-1:0];
            if (scnt_q < CW'(RECORD_DEPTH)) begin
              s1_d.rec = 1'b1;
              scnt_d   = scnt_q + CW'(1);
            end
          end
        end else if (active && !was_active) begin
          in_pulse_d = 1'b1;
          tick_d     = '0;
          wraps_d    = '0;
        end
      end
      MODE_FLUSH: begin
        in_pulse_d = 1'b0;
        tick_d     = '0;
        wraps_d    = '0;
        wtot_d     = '0;
        scnt_d     = '0;
        s1_d.op    = OP_FLUSH;
      end
      MODE_READ: begin
        s1_d.op   = OP_READ;
        s1_d.hit  = (ridx_x < XW'(scnt_q));
        s1_d.addr = ridx_x[AW-1:0];
      end
      MODE_NOP: ;
    endcase
    s1_d.rcnt  = sat_cnt(scnt_d);
    s1_d.match = wtot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pulse_q <= 1'b0;
      prev_q     <= 1'b0;
      tick_q     <= '0;
      wraps_q    <= '0;
      wtot_q     <= '0;
      scnt_q     <= '0;
    end else if (acc) begin
      in_pulse_q <= in_pulse_d;
      prev_q     <= prev_d;
      tick_q     <= tick_d;
      wraps_q    <= wraps_d;
      wtot_q     <= wtot_d;
      scnt_q     <= scnt_d;
    end
  end

  // First stage: period times wrap count, kept modulo the width range.
  s2_t            s2_d, s2_q;
  logic [W_W-1:0] prod_lo;
  logic [W_W-1:0] w_end;

  assign prod_lo = per_eff[W_W-1:0] * s1_q.wraps;

  always_comb begin
    s2_d.op       = s1_q.op;
    s2_d.rec      = s1_q.rec;
    s2_d.tick     = s1_q.tick;
    s2_d.prod     = prod_lo;
    s2_d.addr     = s1_q.addr;
    s2_d.hit      = s1_q.hit;
    s2_d.rcnt     = s1_q.rcnt;
    s2_d.match    = s1_q.match;
    s2_d.fwd      = s2_v_q && (s2_q.op == OP_END) && s2_q.rec && (s2_q.addr == s1_q.addr);
    s2_d.fwd_data = w_end;
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q <= s1_d;
    end
    if (s1_go) begin
      s2_q <= s2_d;
    end
  end

  // Width store memory.
  logic [W_W-1:0] mem [RECORD_DEPTH];
  logic [W_W-1:0] rd_q;

  assign wr_en = s2_v_q && out_adv && (s2_q.op == OP_END) && s2_q.rec;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s2_q.addr] <= w_end;
    end
    if (s1_go) begin
      rd_q <= mem[s1_q.addr];
    end
  end

  // Second stage: width, statistics and result word.
  logic [W_W-1:0]    min_q, min_d, max_q, max_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CW-1:0]     qcnt_q, qcnt_d;
  logic [SUM_W:0]    sum_ext;
  logic [W_W-1:0]    rd_val, w_out;
  logic              qual;
  logic [OUT_DATA_W-1:0] tdata_q;
  logic [OUT_USER_W-1:0] tuser_q;

  assign w_end   = s2_q.tick + s2_q.prod;
  assign rd_val  = s2_q.fwd ? s2_q.fwd_data : rd_q;
  assign qual    = (s2_q.op == OP_END) && s2_q.rec && (w_end > thr_q);
  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(w_end);

  always_comb begin
    min_d  = min_q;
    max_d  = max_q;
    sum_d  = sum_q;
    qcnt_d = qcnt_q;
    w_out  = '0;
    unique case (s2_q.op)
      OP_END: begin
        w_out = w_end;
        if (qual) begin
          if (w_end < min_q) begin
            min_d = w_end;
          end
          if (w_end > max_q) begin
            max_d = w_end;
          end
          sum_d  = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
          qcnt_d = qcnt_q + CW'(1);
        end
      end
      OP_READ: begin
        if (s2_q.hit) begin
          w_out = rd_val;
        end
      end
      OP_FLUSH: begin
        min_d  = '1;
        max_d  = '0;
        sum_d  = '0;
        qcnt_d = '0;
      end
      OP_IDLE: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= '1;
      max_q  <= '0;
      sum_q  <= '0;
      qcnt_q <= '0;
    end else if (s2_v_q && out_adv) begin
      min_q  <= min_d;
      max_q  <= max_d;
      sum_q  <= sum_d;
      qcnt_q <= qcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q && out_adv) begin
      tdata_q <= {{OUT_PAD_W{1'b0}}, sat_cnt(qcnt_d), sum_d, max_d, min_d,
                  s2_q.match, s2_q.rcnt, w_out};
      tuser_q <= {s2_q.rec, (s2_q.op == OP_END)};
    end
  end

  assign m_axis_tdata = tdata_q;
  assign m_axis_tuser = tuser_q;

endmodule

`default_nettype wire

// ===== hdl/pwcs_checker.sv =====
// Port-level assertion checker for the pulse width capture block, with its bind.
`default_nettype none

`include "pulse_width_capture_stats_macros.svh"

module pwcs_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire [pwcs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input wire [pwcs_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  input wire                              m_axis_tvalid,
  input wire                              m_axis_tready
);

  import pwcs_pkg::*;

  logic [CNT_W-1:0] qcnt;
  logic [CNT_W-1:0] rcnt;
  logic [W_W-1:0]   min_w;
  logic [W_W-1:0]   max_w;
  logic [SUM_W-1:0] sum_w;
  logic             stall;
  logic             out_rec;
  logic             out_done;
  logic             no_qual;
  logic             stats_clear;

  assign qcnt        = m_axis_tdata[OFF_QCNT +: CNT_W];
  assign rcnt        = m_axis_tdata[OFF_RCNT +: CNT_W];
  assign min_w       = m_axis_tdata[OFF_MIN +: W_W];
  assign max_w       = m_axis_tdata[OFF_MAX +: W_W];
  assign sum_w       = m_axis_tdata[OFF_SUM +: SUM_W];
  assign stall       = m_axis_tvalid && !m_axis_tready;
  assign out_rec     = m_axis_tvalid && m_axis_tuser[USER_REC];
  assign out_done    = m_axis_tuser[USER_DONE];
  assign no_qual     = m_axis_tvalid && (qcnt == '0);
  assign stats_clear = (min_w == '1) && (max_w == '0) && (sum_w == '0);

  `PWCS_ASSERT_NEXT(a_valid_hold, clk_i, rst_ni, stall, m_axis_tvalid)
  `PWCS_ASSERT_NEXT(a_word_hold, clk_i, rst_ni, stall, $stable({m_axis_tdata, m_axis_tuser}))
  `PWCS_ASSERT_IMP(a_rec_needs_done, clk_i, rst_ni, out_rec, out_done && (rcnt != '0))
  `PWCS_ASSERT_IMP(a_empty_stats, clk_i, rst_ni, no_qual, stats_clear)

endmodule

bind pulse_width_capture_stats pwcs_checker u_pwcs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire
